// ----- sv/rprop_step_size_update_defines.svh -----
// Assertion macros for the Rprop step size update block.
// Included by the top level; assumes clk and rst_n in scope at the point of use.
`ifndef RPROP_STEP_SIZE_UPDATE_DEFINES_SVH
`define RPROP_STEP_SIZE_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RPROP_ASSERT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rprop_step_size_update: assertion failed");
// Next-cycle implication.
`define RPROP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rprop_step_size_update: assertion failed");
`else
`define RPROP_ASSERT(name, ante, cons)
`define RPROP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- sv/rprop_pkg.sv -----
// Shared types and constants of the Rprop step size update block.
// No dependencies; imported by the scale, clamp and top-level modules of the block.
package rprop_pkg;

    localparam int INDEX_W      = 10;
    localparam int GRAD_W       = 32;
    localparam int IN_TDATA_W   = 48;   // index + gradient, padded to bytes
    localparam int FACTOR_W     = 16;
    localparam int FACTOR_SHIFT = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [FACTOR_W-1:0]   GROW_RESET   = 16'd4915;
    localparam logic [FACTOR_W-1:0]   SHRINK_RESET = 16'd2048;
    localparam logic [CFG_DATA_W-1:0] MIN_RESET    = 32'd17;
    localparam logic [CFG_DATA_W-1:0] MAX_RESET    = 32'd838860800;
    localparam logic [CFG_DATA_W-1:0] START_RESET  = 32'd1677722;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROW   = 3'd0,
        CFG_SHRINK = 3'd1,
        CFG_MIN    = 3'd2,
        CFG_MAX    = 3'd3,
        CFG_START  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ACT_INIT   = 1'b0,
        ACT_UPDATE = 1'b1
    } action_t;

    // Per-item control carried down the pipeline.
    typedef struct packed {
        action_t              action;
        logic                 grad_zero;
        logic                 dir_pos;    // negated gradient is positive
        logic                 in_range;
        logic [INDEX_W-1:0]   index;
    } item_ctl_t;

endpackage

// ----- sv/rprop_step_ram.sv -----
// Step size memory: one write port, one read port with registered data.
// Depends on nothing; instantiated by the top level.
module rprop_step_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 33
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rprop_scale.sv -----
// Grow/shrink scaling of a stored step magnitude, with saturation.
// Depends on rprop_pkg; instantiated by the top level.
module rprop_scale #(
    parameter int RATE_BITS = 32
) (
    input  logic [RATE_BITS-1:0]          mag,
    input  logic                          neg,
    input  logic                          dir_pos,
    input  logic [rprop_pkg::FACTOR_W-1:0] grow_factor,
    input  logic [rprop_pkg::FACTOR_W-1:0] shrink_factor,
    output logic [RATE_BITS-1:0]          scaled
);
    import rprop_pkg::*;

    localparam int PROD_W = RATE_BITS + FACTOR_W;
    localparam int SHR_W  = PROD_W - FACTOR_SHIFT;

    logic [FACTOR_W-1:0]  factor;
    logic [PROD_W-1:0]    product;
    logic [SHR_W-1:0]     shifted;
    logic [RATE_BITS-1:0] mag_all_ones;

    // Grow when the stored sign agrees with the negated gradient.
    assign factor       = (neg != dir_pos) ? grow_factor : shrink_factor;
    assign product      = PROD_W'(mag) * PROD_W'(factor);
    assign shifted      = product[PROD_W-1:FACTOR_SHIFT];
    assign mag_all_ones = '1;

    // A zero magnitude yields a zero product, so it stays unscaled.
    assign scaled = (shifted > SHR_W'(mag_all_ones)) ? mag_all_ones
                                                     : shifted[RATE_BITS-1:0];

endmodule

// ----- sv/rprop_clamp.sv -----
// Final step selection: initialize, zero gradient, clamp and sign, delta encode.
// Depends on rprop_pkg; instantiated by the top level.
module rprop_clamp #(
    parameter int RATE_BITS = 32
) (
    input  rprop_pkg::item_ctl_t  ctl,
    input  logic [RATE_BITS-1:0]  scaled,
    input  logic [RATE_BITS-1:0]  lo,
    input  logic [RATE_BITS-1:0]  hi,
    input  logic [RATE_BITS-1:0]  start,
    output logic                  wr_neg,
    output logic [RATE_BITS-1:0]  wr_mag,
    output logic [RATE_BITS:0]    delta
);
    import rprop_pkg::*;

    logic [RATE_BITS-1:0] upper;
    logic [RATE_BITS-1:0] bounded;
    logic [RATE_BITS:0]   mag_ext;

    assign upper   = (scaled < hi) ? scaled : hi;
    assign bounded = (upper > lo) ? upper : lo;   // min wins over max

    always_comb
    begin
        if (ctl.action == ACT_INIT)
        begin
            wr_neg = 1'b0;
            wr_mag = start;
        end
        else if (ctl.grad_zero)
        begin
            wr_neg = 1'b0;
            wr_mag = '0;
        end
        else
        begin
            wr_neg = (bounded != '0) && !ctl.dir_pos;
            wr_mag = bounded;
        end
    end

    assign mag_ext = {1'b0, wr_mag};
    assign delta   = !ctl.in_range ? '0
                   : (wr_neg ? (~mag_ext + (RATE_BITS + 1)'(1)) : mag_ext);

endmodule

// ----- sv/rprop_step_size_update.sv -----
// Top level of the Rprop step size update block.
// Depends on rprop_pkg, rprop_step_ram, rprop_scale, rprop_clamp and the defines header.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five registers (grow,
//   shrink, min, max, start); cfg_ready is always high. Write only while idle.
//   s_axis carries one item per handshake: tuser is the action (initialize or
//   update), tdata holds weight_index and gradient. m_axis returns exactly one
//   item per input item: tdata holds delta_weight and index_echo.
// Throughput: one item per cycle while m_axis_tready is high. The step memory
//   is read on acceptance and written as the item leaves the clamp stage; the
//   read-scale-clamp loop closes through forwarding from the clamp stage and a
//   last-write register, so back-to-back items on the same weight need no interlock.
// Pipeline: an accepted item passes the memory read, the scale/multiply register
//   and the output register before m_axis_tvalid rises.
// Reset: clears pipeline valids, the forwarding register and the config
//   registers to their defaults. Step memory contents are not cleared; an
//   entry must be initialized before its first update.
// Stall: when m_axis_tready is low the output register holds; the two inner
//   stages keep accepting until they fill, then s_axis_tready drops.
`include "rprop_step_size_update_defines.svh"
module rprop_step_size_update #(
    parameter int NUM_WEIGHTS = 1024,
    parameter int RATE_BITS   = 32,
    localparam int OUT_TDATA_W = ((RATE_BITS + 1 + rprop_pkg::INDEX_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rprop_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rprop_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rprop_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // weight_index[9:0], gradient[41:10]
    input  logic                               s_axis_tuser,  // action[0]
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [OUT_TDATA_W-1:0]             m_axis_tdata   // delta_weight, then index_echo
);
    import rprop_pkg::*;

    localparam int ADDR_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int EXT_W  = ADDR_W + INDEX_W;
    localparam int DATA_W = RATE_BITS + 1;
    localparam int CW     = (RATE_BITS > CFG_DATA_W) ? RATE_BITS : CFG_DATA_W;

    // Cap a 32-bit config value to the largest magnitude.
    function automatic logic [RATE_BITS-1:0] cap_cfg(input logic [CFG_DATA_W-1:0] v);
        logic [CW-1:0]        wide;
        logic [RATE_BITS-1:0] ones;
        wide = CW'(v);
        ones = '1;
        return (wide > CW'(ones)) ? ones : wide[RATE_BITS-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [FACTOR_W-1:0]  grow_reg, shrink_reg;
    logic [RATE_BITS-1:0] lo_reg, hi_reg, start_reg;
    logic [RATE_BITS-1:0] cfg_capped;

    assign cfg_ready  = 1'b1;
    assign cfg_capped = cap_cfg(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_reg   <= GROW_RESET;
            shrink_reg <= SHRINK_RESET;
            lo_reg     <= cap_cfg(MIN_RESET);
            hi_reg     <= cap_cfg(MAX_RESET);
            start_reg  <= cap_cfg(START_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GROW:   grow_reg   <= cfg_data[FACTOR_W-1:0];
                CFG_SHRINK: shrink_reg <= cfg_data[FACTOR_W-1:0];
                CFG_MIN:    lo_reg     <= cfg_capped;
                CFG_MAX:    hi_reg     <= cfg_capped;
                CFG_START:  start_reg  <= cfg_capped;
                default:    ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic m_valid_reg,  m_valid_next;
    logic out_free, s2_free, s2_move, s1_free, s1_move, s1_load;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s2_move       = s2_valid_reg && out_free;
    assign s2_free       = !s2_valid_reg || out_free;
    assign s1_move       = s1_valid_reg && s2_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign s_axis_tready = s1_free;
    assign s1_load       = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s1_move);
    assign s2_valid_next = s1_move || (s2_valid_reg && !s2_move);
    assign m_valid_next  = s2_move || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // ---------------- stage 0: decode and issue memory read ----------------
    logic [INDEX_W-1:0] in_index;
    logic [GRAD_W-1:0]  in_grad;
    logic [EXT_W-1:0]   in_index_ext;
    logic [ADDR_W-1:0]  rd_addr;
    item_ctl_t          in_ctl;

    assign in_index     = s_axis_tdata[INDEX_W-1:0];
    assign in_grad      = s_axis_tdata[INDEX_W+GRAD_W-1:INDEX_W];
    assign in_index_ext = EXT_W'(in_index);
    assign rd_addr      = in_index_ext[ADDR_W-1:0];

    always_comb
    begin
        in_ctl.action    = action_t'(s_axis_tuser);
        in_ctl.grad_zero = (in_grad == '0);
        in_ctl.dir_pos   = in_grad[GRAD_W-1];  // negative gradient: step up
        in_ctl.in_range  = (32'(in_index) < 32'(NUM_WEIGHTS));
        in_ctl.index     = in_index;
    end

    // ---------------- stage 1: forward, scale ----------------
    item_ctl_t            s1_ctl_reg;
    logic [DATA_W-1:0]    ram_rdata;
    logic                 mem_we;
    logic [ADDR_W-1:0]    wr_addr;
    logic [EXT_W-1:0]     wr_index_ext;
    logic                 wr_neg;
    logic [RATE_BITS-1:0] wr_mag;
    logic [RATE_BITS:0]   s2_delta;

    item_ctl_t            s2_ctl_reg;
    logic [RATE_BITS-1:0] s2_scaled_reg, s2_scaled_next;

    logic                 lw_valid_reg;
    logic [INDEX_W-1:0]   lw_index_reg;
    logic                 lw_neg_reg;
    logic [RATE_BITS-1:0] lw_mag_reg;

    logic                 s2_hit, lw_hit;
    logic                 cur_neg;
    logic [RATE_BITS-1:0] cur_mag;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_ctl_reg <= in_ctl;
        end
    end

    rprop_step_ram #(
        .DEPTH  (NUM_WEIGHTS),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_addr),
        .wdata ({wr_neg, wr_mag}),
        .re    (s1_load),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Newest value wins: the item in the clamp stage, then the last write,
    // then the memory read taken when this item was accepted.
    assign s2_hit = s2_valid_reg && s2_ctl_reg.in_range
                    && (s2_ctl_reg.index == s1_ctl_reg.index);
    assign lw_hit = lw_valid_reg && (lw_index_reg == s1_ctl_reg.index);

    always_comb
    begin
        priority if (s2_hit)
        begin
            cur_neg = wr_neg;
            cur_mag = wr_mag;
        end
        else if (lw_hit)
        begin
            cur_neg = lw_neg_reg;
            cur_mag = lw_mag_reg;
        end
        else
        begin
            cur_neg = ram_rdata[DATA_W-1];
            cur_mag = ram_rdata[RATE_BITS-1:0];
        end
    end

    rprop_scale #(
        .RATE_BITS (RATE_BITS)
    ) u_scale (
        .mag           (cur_mag),
        .neg           (cur_neg),
        .dir_pos       (s1_ctl_reg.dir_pos),
        .grow_factor   (grow_reg),
        .shrink_factor (shrink_reg),
        .scaled        (s2_scaled_next)
    );

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_ctl_reg    <= s1_ctl_reg;
            s2_scaled_reg <= s2_scaled_next;
        end
    end

    // ---------------- stage 2: clamp, write back, emit ----------------
    rprop_clamp #(
        .RATE_BITS (RATE_BITS)
    ) u_clamp (
        .ctl    (s2_ctl_reg),
        .scaled (s2_scaled_reg),
        .lo     (lo_reg),
        .hi     (hi_reg),
        .start  (start_reg),
        .wr_neg (wr_neg),
        .wr_mag (wr_mag),
        .delta  (s2_delta)
    );

    assign mem_we       = s2_move && s2_ctl_reg.in_range;
    assign wr_index_ext = EXT_W'(s2_ctl_reg.index);
    assign wr_addr      = wr_index_ext[ADDR_W-1:0];

    // Hold the most recent write for items whose read raced it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (mem_we)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lw_index_reg <= s2_ctl_reg.index;
            lw_neg_reg   <= wr_neg;
            lw_mag_reg   <= wr_mag;
        end
    end

    // ---------------- output register ----------------
    logic [RATE_BITS:0]   m_delta_reg;
    logic [INDEX_W-1:0]   m_index_reg;
    logic                 m_out_of_range;

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            m_delta_reg <= s2_delta;
            m_index_reg <= s2_ctl_reg.index;
        end
    end

    assign m_axis_tvalid  = m_valid_reg;
    assign m_axis_tdata   = OUT_TDATA_W'({m_index_reg, m_delta_reg});
    assign m_out_of_range = !(32'(m_index_reg) < 32'(NUM_WEIGHTS));

    // ---------------- assertions ----------------
    `RPROP_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_reg && !s1_free, s1_valid_reg)
    `RPROP_ASSERT(a_zero_step_not_neg, mem_we, !(wr_neg && (wr_mag == '0)))
    `RPROP_ASSERT(a_out_of_range_zero, m_valid_reg && m_out_of_range, m_delta_reg == '0)

endmodule

// ----- bench/rprop_step_size_update_check.sv -----
`timescale 1ns / 1ps
// Result checker for the Rprop step size update block: watches the config, input and
// result channels, predicts each delta and compares it. Depends on rprop_pkg.
module rprop_step_size_update_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rprop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rprop_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [rprop_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [47:0]                      m_axis_tdata,
    output int                               fail_count,
    output int                               pending
);
    import rprop_pkg::*;

    typedef struct packed {
        logic [32:0]        delta;
        logic [INDEX_W-1:0] index;
    } delta_item_t;

    // Own copy of the per-weight step (sign and magnitude) and of the registers.
    logic                  rate_neg [1024];
    logic [31:0]           rate_mag [1024];
    logic [FACTOR_W-1:0]   grow_f;
    logic [FACTOR_W-1:0]   shrink_f;
    logic [31:0]           min_rate;
    logic [31:0]           max_rate;
    logic [31:0]           start_rate;

    delta_item_t expected_deltas [$];
    delta_item_t want;
    logic [32:0] got_delta;
    logic [INDEX_W-1:0] got_index;

    initial fail_count = 0;
    initial pending = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Q8.24 magnitude times Q4.12 factor, truncated, saturating at 32 bits.
    function automatic logic [31:0] scale_rate(input logic [31:0] mag,
                                               input logic [FACTOR_W-1:0] f);
        logic [47:0] prod;
        prod = {16'b0, mag} * {32'b0, f};
        prod = prod >> FACTOR_SHIFT;
        return (prod > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    // Work out the new step of one weight, store it and return the emitted delta.
    function automatic delta_item_t next_step(input action_t act,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [GRAD_W-1:0] grad);
        logic        neg;
        logic [31:0] mag;
        logic        dir_pos;
        delta_item_t r;
        if (act == ACT_INIT)
        begin
            neg = 1'b0;
            mag = start_rate;
        end
        else if (grad == '0)
        begin
            neg = 1'b0;
            mag = '0;
        end
        else
        begin
            dir_pos = grad[GRAD_W-1];
            neg = rate_neg[idx];
            mag = rate_mag[idx];
            if (mag != '0)
                mag = (neg != dir_pos) ? scale_rate(mag, grow_f) : scale_rate(mag, shrink_f);
            if (mag > max_rate)
                mag = max_rate;
            if (mag < min_rate)
                mag = min_rate;
            neg = (mag != '0) && !dir_pos;
        end
        rate_neg[idx] = neg;
        rate_mag[idx] = mag;
        r.delta = neg ? (33'd0 - {1'b0, mag}) : {1'b0, mag};
        r.index = idx;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_f     = GROW_RESET;
            shrink_f   = SHRINK_RESET;
            min_rate   = MIN_RESET;
            max_rate   = MAX_RESET;
            start_rate = START_RESET;
            for (int i = 0; i < 1024; i++)
            begin
                rate_neg[i] = 1'b0;
                rate_mag[i] = '0;
            end
            expected_deltas.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GROW:   grow_f = cfg_data[FACTOR_W-1:0];
                    CFG_SHRINK: shrink_f = cfg_data[FACTOR_W-1:0];
                    CFG_MIN:    min_rate = cfg_data;
                    CFG_MAX:    max_rate = cfg_data;
                    CFG_START:  start_rate = cfg_data;
                    default:    ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_deltas.push_back(next_step(action_t'(s_axis_tuser),
                                                    s_axis_tdata[INDEX_W-1:0],
                                                    s_axis_tdata[INDEX_W +: GRAD_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_delta = m_axis_tdata[32:0];
                got_index = m_axis_tdata[33 +: INDEX_W];
                if (expected_deltas.size() == 0)
                    report_mismatch($sformatf("unexpected result delta %h index %0d",
                                              got_delta, got_index));
                else
                begin
                    want = expected_deltas.pop_front();
                    if (got_delta !== want.delta)
                        report_mismatch($sformatf("delta_weight %h, want %h (index %0d)",
                                                  got_delta, want.delta, want.index));
                    if (got_index !== want.index)
                        report_mismatch($sformatf("index_echo %0d, want %0d",
                                                  got_index, want.index));
                end
            end
        end
        pending = expected_deltas.size();
    end

endmodule

// ----- bench/rprop_step_size_update_test.sv -----
`timescale 1ns / 1ps
// Top of the Rprop step size update bench: clock, reset, stimulus and verdict.
// Depends on rprop_pkg, the block and rprop_step_size_update_check.
module rprop_step_size_update_test;
    import rprop_pkg::*;

    localparam int OUT_W = 48;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // weight_index[9:0], gradient[41:10]
    logic                  s_axis_tuser = 1'b0; // action[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // delta_weight[32:0], index_echo[42:33]
    int                    fail_count;
    int                    pending;

    // Stimulus bookkeeping: which weights hold a defined step, and the hot set
    // that most updates hit so that weights see long runs of updates.
    bit                    seeded [1024];
    int                    seeded_list [$];
    int                    hot_idx [$];
    int                    last_idx = 0;
    bit                    last_sign = 1'b0;
    bit                    quiet = 1'b0;        // no idling on either side
    int                    stall_left = 0;

    rprop_step_size_update uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rprop_step_size_update_check delta_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial
    begin
        #4ms;
        $display("rprop_step_size_update verification failed");
        $finish;
    end

    // Result side: drop tready at random, hold it high when quiet.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Offer one item and return right after the edge that takes it. tready is
    // checked at the falling edge, where it is settled for the coming rising edge.
    // tvalid stays high into the next item unless a gap is inserted.
    task automatic send_item(input action_t act, input int idx, input logic [31:0] grad);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'b0, grad, idx[INDEX_W-1:0]};
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        if (act == ACT_INIT || grad == '0)
        begin
            if (!seeded[idx])
                seeded_list.push_back(idx);
            seeded[idx] = 1'b1;
        end
    endtask

    // Hold off the sender until every result is back, then let the pipeline
    // drain fully.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    // Write all five registers back to back while the block is idle.
    task automatic load_config(input logic [15:0] grow, input logic [15:0] shrink,
                               input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] start);
        drain_results();
        write_reg(CFG_GROW, {16'b0, grow});
        write_reg(CFG_SHRINK, {16'b0, shrink});
        write_reg(CFG_MIN, lo);
        write_reg(CFG_MAX, hi);
        write_reg(CFG_START, start);
        cfg_valid <= 1'b0;
    endtask

    // One random item. Mostly updates of weights already set up, often on the
    // same weight and with the same sign so steps grow into the clamps; the
    // rest are initializations, zero gradients and edge gradients.
    task automatic send_random_item();
        int          idx;
        logic [31:0] grad;
        action_t     act;
        if ($urandom_range(0, 19) == 0)
        begin
            // stray initialization anywhere in the index range
            send_item(ACT_INIT, $urandom_range(0, 1023), '0);
            return;
        end
        if ($urandom_range(0, 1) == 0)
            idx = last_idx;
        else if ($urandom_range(0, 15) == 0)
            idx = seeded_list[$urandom_range(0, seeded_list.size() - 1)];
        else
            idx = hot_idx[$urandom_range(0, hot_idx.size() - 1)];
        act = ($urandom_range(0, 9) == 0 || !seeded[idx]) ? ACT_INIT : ACT_UPDATE;
        case ($urandom_range(0, 9))
            0: grad = '0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: grad = 32'hFFFF_FFFF;
                    1: grad = 32'h0000_0001;
                    2: grad = 32'h8000_0000;
                    default: grad = 32'h7FFF_FFFF;
                endcase
            end
            2, 3, 4:
            begin
                grad = $urandom_range(1, 100000);
                if (last_sign)
                    grad = -grad;
            end
            default: grad = $urandom();
        endcase
        if (act == ACT_INIT && $urandom_range(0, 1) == 0)
            grad = $urandom();   // gradient bits are don't-care for init
        send_item(act, idx, grad);
        last_idx = idx;
        if (act == ACT_UPDATE && grad != '0)
            last_sign = grad[31];
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_random_item();
    endtask

    initial
    begin
        hot_idx = '{0, 1023, 1, 512, 341, 682};
        repeat (26) hot_idx.push_back($urandom_range(0, 1023));

        // Hold reset once at the start, then release it.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values.
        send_item(ACT_INIT, 0, '0);
        send_item(ACT_INIT, 1023, 32'hFFFF_FFFF);
        send_item(ACT_UPDATE, 0, 32'hFFFF_FFFF);   // agree: grow
        send_item(ACT_UPDATE, 0, 32'h8000_0000);   // most negative gradient, grow
        send_item(ACT_UPDATE, 0, 32'h0000_0001);   // disagree: shrink
        send_item(ACT_UPDATE, 0, 32'h7FFF_FFFF);   // agree with negative step
        send_item(ACT_UPDATE, 0, '0);              // zero gradient stores zero
        send_item(ACT_UPDATE, 0, 32'h0000_0005);   // zero step: clamp up to min
        send_item(ACT_UPDATE, 0, 32'hFFFF_FFFB);   // flip sign from min
        send_item(ACT_UPDATE, 1023, '0);
        send_item(ACT_UPDATE, 1023, 32'h8000_0000);
        send_item(ACT_INIT, 1023, '0);
        repeat (8) send_item(ACT_UPDATE, 1023, 32'hFFFF_0000);  // grow on each repeat
        send_item(ACT_UPDATE, 1023, 32'h0000_FFFF);
        send_item(ACT_INIT, 512, 32'h5555_5555);
        send_item(ACT_UPDATE, 512, 32'hAAAA_AAAA);

        // Midrange values, with a pause for all results part way through.
        load_config(16'd6144, 16'd1024, 32'd1000, 32'h0800_0000, 32'h0010_0000);
        random_phase(60);
        drain_results();
        random_phase(60);

        // Largest factors and widest clamps: products saturate.
        load_config(16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(110);

        // Zero factors and zero start: every scaled step collapses to min.
        load_config(16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        random_phase(100);

        // Min above max: min wins.
        load_config(16'd4915, 16'd2048, 32'h3000_0000, 32'h0000_0100, $urandom());
        random_phase(100);

        // Both clamps at zero: all update deltas zero, initializations give start.
        load_config(16'd8192, 16'd100, 32'd0, 32'd0, 32'h0000_0001);
        random_phase(80);

        // Fully random register values.
        load_config(16'($urandom()), 16'($urandom()), $urandom_range(0, 65535),
                    $urandom(), $urandom());
        random_phase(110);

        // Back to the reset values, then a final stretch without any idling.
        load_config(GROW_RESET, SHRINK_RESET, MIN_RESET, MAX_RESET, START_RESET);
        random_phase(60);
        quiet = 1'b1;
        random_phase(100);

        // Let every result come back, then wait on for strays.
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("rprop_step_size_update verification clean");
        else
            $display("rprop_step_size_update verification failed");
        $finish;
    end

endmodule
